// ===== hdl/crast_pkg.sv =====
// Package with shared constants and types for the circle rasterizer.
`default_nettype none

package crast_pkg;

  localparam int COORD_W     = 14;
  localparam int CENTER_W    = 12;
  localparam int RADIUS_W    = 11;
  localparam int OFFSET_W    = 12;
  localparam int DECISION_W  = 14;
  localparam int QUEUE_DEPTH = 2;
  localparam int IDX_W       = 3;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam logic STYLE_OUTLINE = 1'b0;
  localparam logic STYLE_FILL    = 1'b1;

  localparam logic [IDX_W-1:0] LAST_OUTLINE = 3'd7;
  localparam logic [IDX_W-1:0] LAST_FILL    = 3'd3;

  typedef struct packed {
    logic        [CENTER_W-1:0] cx;
    logic        [CENTER_W-1:0] cy;
    logic        [OFFSET_W-1:0] across;
    logic signed [OFFSET_W-1:0] down;
    logic                       style;
    logic                       done;
  } job_t;

endpackage

`default_nettype wire

// ===== hdl/crast_if.sv =====
// Request channel interfaces for the circle rasterizer input and output.
`default_nettype none

interface crast_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [crast_pkg::CENTER_W-1:0] center_x;
  logic [crast_pkg::CENTER_W-1:0] center_y;
  logic [crast_pkg::RADIUS_W-1:0] circle_radius;
  logic                          fill_style;

  modport source (output valid, mode, center_x, center_y, circle_radius, fill_style,
                  input ready);
  modport sink (input valid, mode, center_x, center_y, circle_radius, fill_style,
                output ready);
endinterface

interface crast_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [crast_pkg::COORD_W-1:0] span_x_start;
  logic signed [crast_pkg::COORD_W-1:0] span_x_end;
  logic signed [crast_pkg::COORD_W-1:0] span_row;
  logic                                step_last;
  logic                                circle_done;

  modport source (output valid, span_x_start, span_x_end, span_row, step_last, circle_done,
                  input ready);
  modport sink (input valid, span_x_start, span_x_end, span_row, step_last, circle_done,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/crast_front.sv =====
// Front end: takes requests, holds the circle state and issues one job per step.
`default_nettype none

module crast_front (
  input  wire logic              clk,
  input  wire logic              rst,
  crast_in_if.sink               item,
  input  wire logic              queue_full,
  output logic                   push,
  output crast_pkg::job_t        job
);
  import crast_pkg::*;

  logic        [CENTER_W-1:0]   held_center_x;
  logic        [CENTER_W-1:0]   held_center_y;
  logic        [RADIUS_W-1:0]   held_radius;
  logic                         held_style;
  logic        [OFFSET_W-1:0]   offset_across;
  logic signed [OFFSET_W-1:0]   offset_down;
  logic signed [DECISION_W-1:0] decision_value;
  logic                         circle_active;

  logic [OFFSET_W-1:0]          offset_across_next;
  logic signed [OFFSET_W-1:0]   offset_down_next;
  logic signed [DECISION_W-1:0] decision_value_next;
  logic                         accept;
  logic                         finish;

  logic signed [DECISION_W:0] a_w;
  logic signed [DECISION_W:0] d_w;
  logic signed [DECISION_W:0] dv_w;
  logic signed [DECISION_W:0] r_w;
  logic signed [DECISION_W:0] dv_sum;

  assign item.ready = !queue_full;
  assign accept     = item.valid && item.ready;
  assign push       = accept && (item.mode == MODE_STEP) && circle_active;

  always_comb begin
    a_w  = $signed({{(DECISION_W + 1 - OFFSET_W){1'b0}}, offset_across});
    d_w  = $signed({{(DECISION_W + 1 - OFFSET_W){offset_down[OFFSET_W-1]}}, offset_down});
    dv_w = $signed({decision_value[DECISION_W-1], decision_value});
    r_w  = $signed({{(DECISION_W + 1 - RADIUS_W){1'b0}}, held_radius});
    offset_across_next = offset_across;
    offset_down_next   = offset_down;
    if (dv_w >= (a_w <<< 1)) begin
      dv_sum             = dv_w - (a_w <<< 1) - 15'sd1;
      offset_across_next = offset_across + 12'd1;
    end else if (dv_w < ((r_w - d_w) <<< 1)) begin
      dv_sum           = dv_w + (d_w <<< 1) - 15'sd1;
      offset_down_next = offset_down - 12'sd1;
    end else begin
      dv_sum             = dv_w + ((d_w - a_w - 15'sd1) <<< 1);
      offset_down_next   = offset_down - 12'sd1;
      offset_across_next = offset_across + 12'd1;
    end
    decision_value_next = dv_sum[DECISION_W-1:0];
    finish = $signed({offset_down_next[OFFSET_W-1], offset_down_next})
             < $signed({1'b0, offset_across_next});
  end

  always_comb begin
    job.cx     = held_center_x;
    job.cy     = held_center_y;
    job.across = offset_across;
    job.down   = offset_down;
    job.style  = held_style;
    job.done   = finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_center_x  <= '0;
      held_center_y  <= '0;
      held_radius    <= '0;
      held_style     <= STYLE_OUTLINE;
      offset_across  <= '0;
      offset_down    <= '0;
      decision_value <= '0;
      circle_active  <= 1'b0;
    end else if (accept && (item.mode == MODE_START)) begin
      held_center_x  <= item.center_x;
      held_center_y  <= item.center_y;
      held_radius    <= item.circle_radius;
      held_style     <= item.fill_style;
      offset_across  <= '0;
      offset_down    <= $signed({1'b0, item.circle_radius});
      decision_value <= $signed({{(DECISION_W - RADIUS_W){1'b0}}, item.circle_radius})
                        - 14'sd1;
      circle_active  <= 1'b1;
    end else if (push) begin
      offset_across  <= offset_across_next;
      offset_down    <= offset_down_next;
      decision_value <= decision_value_next;
      circle_active  <= !finish;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/crast_queue.sv =====
// Small job queue between the front end and the span generator.
`default_nettype none

module crast_queue #(
  parameter int Depth = crast_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire crast_pkg::job_t  push_job,
  input  wire logic             pop,
  output logic                  full,
  output logic                  head_valid,
  output crast_pkg::job_t       head_job
);
  import crast_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  job_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("Queue written while full.");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("Queue read while empty.");
`endif

endmodule

`default_nettype wire

// ===== hdl/crast_back.sv =====
// Back end: turns each queued job into its outline points or fill spans.
`default_nettype none

module crast_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire crast_pkg::job_t  head_job,
  output logic                  pop,
  crast_out_if.source           span
);
  import crast_pkg::*;

  logic [IDX_W-1:0]          idx;
  logic [IDX_W-1:0]          last_idx;
  logic                      load;
  logic                      is_last;
  logic signed [COORD_W-1:0] cx_w;
  logic signed [COORD_W-1:0] cy_w;
  logic signed [COORD_W-1:0] a_w;
  logic signed [COORD_W-1:0] d_w;
  logic signed [COORD_W-1:0] x_off;
  logic signed [COORD_W-1:0] r_off;
  logic signed [COORD_W-1:0] xs_val;
  logic signed [COORD_W-1:0] xe_val;
  logic signed [COORD_W-1:0] row_val;

  assign last_idx = (head_job.style == STYLE_FILL) ? LAST_FILL : LAST_OUTLINE;
  assign is_last  = (idx == last_idx);
  assign load     = head_valid && (!span.valid || span.ready);
  assign pop      = load && is_last;

  always_comb begin
    cx_w = $signed({{(COORD_W - CENTER_W){1'b0}}, head_job.cx});
    cy_w = $signed({{(COORD_W - CENTER_W){1'b0}}, head_job.cy});
    a_w  = $signed({{(COORD_W - OFFSET_W){1'b0}}, head_job.across});
    d_w  = $signed({{(COORD_W - OFFSET_W){head_job.down[OFFSET_W-1]}}, head_job.down});
    if (head_job.style == STYLE_FILL) begin
      x_off   = (idx == 3'd0 || idx == 3'd3) ? d_w : a_w;
      r_off   = (idx == 3'd0 || idx == 3'd3) ? a_w : d_w;
      xs_val  = cx_w - x_off;
      xe_val  = cx_w + x_off;
      row_val = idx[1] ? (cy_w - r_off) : (cy_w + r_off);
    end else begin
      x_off   = idx[0] ? d_w : a_w;
      r_off   = idx[0] ? a_w : d_w;
      xs_val  = idx[1] ? (cx_w - x_off) : (cx_w + x_off);
      xe_val  = xs_val;
      row_val = idx[2] ? (cy_w - r_off) : (cy_w + r_off);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      span.span_x_start <= xs_val;
      span.span_x_end   <= xe_val;
      span.span_row     <= row_val;
      span.step_last    <= is_last;
      span.circle_done  <= is_last && head_job.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      span.valid <= 1'b0;
    end else begin
      if (load) begin
        idx        <= is_last ? '0 : idx + 1'b1;
        span.valid <= 1'b1;
      end else if (span.ready) begin
        span.valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_fill_idx: assert property (@(posedge clk) disable iff (rst)
    head_valid && (head_job.style == STYLE_FILL) |-> idx <= LAST_FILL)
    else $error("Fill job index past its last span.");
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    span.valid && span.circle_done |-> span.step_last)
    else $error("Circle end flagged on a request that does not end its step.");
  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> idx == '0)
    else $error("Span index left mid-job with no job queued.");
`endif

endmodule

`default_nettype wire

// ===== hdl/circle_rasterizer_unit.sv =====
// Circle rasterizer top level: front end, job queue and span generator.
//
// The item channel takes start requests (mode 0), which load the center, radius and
// style, and step requests (mode 1), which each produce the points or spans of one
// octant step. The span channel returns one point or span per request.
// A step request in outline style yields eight requests on the span channel, in fill
// style four; the final one of a step has step_last set, and circle_done marks the
// final one of the circle. Start requests and steps on an idle circle yield nothing.
// The first span of a step passes through the job queue and then the span output
// register, and it can be held behind earlier jobs or a stalled span channel. The
// span generator delivers one request per cycle while a job is queued and the span
// channel takes them; start requests never reach it.
// The front end keeps accepting requests while a job queue of QueueDepth entries has
// room, so a stalled span channel holds the item channel only once the queue is full.
// Reset clears the circle state, empties the queue and drops any pending span.
`default_nettype none

module circle_rasterizer_unit #(
  parameter int QueueDepth = crast_pkg::QUEUE_DEPTH
) (
  input wire logic    clk,
  input wire logic    rst,
  crast_in_if.sink    item,
  crast_out_if.source span
);
  import crast_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_head_valid;
  job_t push_job;
  job_t head_job;

  crast_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .queue_full (q_full),
    .push       (q_push),
    .job        (push_job)
  );

  crast_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (push_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_job   (head_job)
  );

  crast_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .span       (span)
  );

endmodule

`default_nettype wire
